// File: design/sle_pkg.sv
// ----------------------------------------------------------------------------
// sle_pkg
// Shared types and codes of the sorted list engine: command and response
// words, operation and status codes, compare result, parameter defaults.
// ----------------------------------------------------------------------------
`default_nettype none

package sle_pkg;

    localparam int DEF_CAPACITY  = 16;
    localparam int DEF_KEY_WIDTH = 16;

    localparam logic [2:0] OP_INSERT = 3'd0;
    localparam logic [2:0] OP_DELETE = 3'd1;
    localparam logic [2:0] OP_SEARCH = 3'd2;
    localparam logic [2:0] OP_CLEAR  = 3'd3;
    localparam logic [2:0] OP_REWIND = 3'd4;
    localparam logic [2:0] OP_NEXT   = 3'd5;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_FULL      = 2'd1;
    localparam logic [1:0] ST_NOT_FOUND = 2'd2;
    localparam logic [1:0] ST_PAST_END  = 2'd3;

    typedef struct packed {
        logic [2:0]  operation;
        logic [15:0] key;
    } t_cmd_word;

    typedef struct packed {
        logic [15:0] item_out;
        logic        found;
        logic [4:0]  count;
        logic        is_full;
        logic        list_empty;
        logic [1:0]  status;
    } t_rsp_word;

    typedef struct packed {
        logic gt;
        logic eq;
    } t_cmp_res;

endpackage

`default_nettype wire

// File: design/sle_mem.sv
// ----------------------------------------------------------------------------
// sle_mem
// Key store: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module sle_mem #(
    parameter int DEPTH = sle_pkg::DEF_CAPACITY,
    parameter int WIDTH = sle_pkg::DEF_KEY_WIDTH,
    localparam int AW   = $clog2(DEPTH)
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

// File: design/sle_cmp.sv
// ----------------------------------------------------------------------------
// sle_cmp
// Shared key comparator: tests a stored entry against the operand key.
// ----------------------------------------------------------------------------
`default_nettype none

module sle_cmp #(
    parameter int KEY_WIDTH = sle_pkg::DEF_KEY_WIDTH
) (
    input  wire logic [KEY_WIDTH-1:0] i_entry,
    input  wire logic [KEY_WIDTH-1:0] i_key,
    output sle_pkg::t_cmp_res         o_res
);

    always_comb begin
        o_res.gt = (i_entry > i_key);
        o_res.eq = (i_entry == i_key);
    end

endmodule

`default_nettype wire

// File: design/sorted_list_engine.sv
// ----------------------------------------------------------------------------
// sorted_list_engine
// Sorted key list with count and read cursor, one entry step per cycle.
// ----------------------------------------------------------------------------
// Usage:
//   Drive i_cmd (operation, key) with i_start while o_busy is low; the word
//   is taken at that edge. Exactly one result word follows on o_result,
//   marked by o_valid for one cycle. The receiver cannot stall the block.
// Steps:
//   Every entry visited uses the single memory read port and the shared
//   comparator.
//   insert: no entry step when full or empty, else each larger key is moved
//           up one place from the tail before the new key is written.
//   delete/search: scan from the head, at most count entries.
//   read next: reads the entry at the cursor unless past end. clear, rewind,
//   unused codes: no entry step. o_valid rises the cycle after the last step;
//   o_busy is already low then, so the next word may be taken while the result is shown.
// Reset:
//   Synchronous, active low. Count and cursor go to zero; the key store is
//   not cleared, since only entries below the count are ever read.
// ----------------------------------------------------------------------------
`default_nettype none

module sorted_list_engine #(
    parameter int CAPACITY  = sle_pkg::DEF_CAPACITY,
    parameter int KEY_WIDTH = sle_pkg::DEF_KEY_WIDTH
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_start,
    input  wire sle_pkg::t_cmd_word i_cmd,
    output logic                    o_busy,
    output logic                    o_valid,
    output sle_pkg::t_rsp_word      o_result
);

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam logic [CW-1:0] CAP_CNT = CW'(CAPACITY);
    localparam logic [CW-1:0] ZERO    = CW'(0);
    localparam logic [CW-1:0] ONE     = CW'(1);
    localparam logic [CW-1:0] TWO     = CW'(2);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_CMP  = 3'b010,
        S_PUT  = 3'b100
    } t_state;

    t_state                r_state, n_state;
    logic [2:0]            r_op, n_op;
    logic [KEY_WIDTH-1:0]  r_key, n_key;
    logic [CW-1:0]         r_cnt, n_cnt;
    logic [CW-1:0]         r_cur, n_cur;
    logic [CW-1:0]         r_idx, n_idx;
    logic                  r_hit, n_hit;
    logic                  r_valid, n_valid;
    logic [15:0]           r_item, n_item;
    logic                  r_found, n_found;
    logic [1:0]            r_status, n_status;

    logic                  mem_we;
    logic [AW-1:0]         mem_waddr;
    logic [KEY_WIDTH-1:0]  mem_wdata;
    logic [CW-1:0]         rd_sel;
    logic [KEY_WIDTH-1:0]  rdata;
    sle_pkg::t_cmp_res     cmp;

    logic [KEY_WIDTH+15:0] key_ext;
    logic [KEY_WIDTH-1:0]  key_in;
    logic [KEY_WIDTH+15:0] rd_ext;
    logic [CW+4:0]         cnt_ext;
    logic [CW-1:0]         idx_m1;
    logic [CW-1:0]         idx_m2;
    logic [CW-1:0]         idx_p1;
    logic [CW-1:0]         cnt_m1;
    logic                  hit_now;

    assign key_ext = {{KEY_WIDTH{1'b0}}, i_cmd.key};
    assign key_in  = key_ext[KEY_WIDTH-1:0];
    assign rd_ext  = {16'b0, rdata};
    assign cnt_ext = {5'b0, r_cnt};
    assign idx_m1  = r_idx - ONE;
    assign idx_m2  = r_idx - TWO;
    assign idx_p1  = r_idx + ONE;
    assign cnt_m1  = r_cnt - ONE;
    assign hit_now = r_hit | cmp.eq;

    sle_mem #(
        .DEPTH (CAPACITY),
        .WIDTH (KEY_WIDTH)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (rd_sel[AW-1:0]),
        .o_rdata (rdata)
    );

    sle_cmp #(
        .KEY_WIDTH (KEY_WIDTH)
    ) u_cmp (
        .i_entry (rdata),
        .i_key   (r_key),
        .o_res   (cmp)
    );

    always_comb begin
        n_state   = r_state;
        n_op      = r_op;
        n_key     = r_key;
        n_cnt     = r_cnt;
        n_cur     = r_cur;
        n_idx     = r_idx;
        n_hit     = r_hit;
        n_valid   = 1'b0;
        n_item    = r_item;
        n_found   = r_found;
        n_status  = r_status;
        mem_we    = 1'b0;
        mem_waddr = r_idx[AW-1:0];
        mem_wdata = r_key;
        rd_sel    = r_idx;

        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_op     = i_cmd.operation;
                    n_key    = key_in;
                    n_item   = '0;
                    n_found  = 1'b0;
                    n_status = sle_pkg::ST_OK;
                    n_hit    = 1'b0;
                    priority if (i_cmd.operation == sle_pkg::OP_INSERT) begin
                        if (r_cnt == CAP_CNT) begin
                            n_status = sle_pkg::ST_FULL;
                            n_valid  = 1'b1;
                        end else if (r_cnt == ZERO) begin
                            mem_we    = 1'b1;
                            mem_waddr = '0;
                            mem_wdata = key_in;
                            n_cnt     = ONE;
                            n_valid   = 1'b1;
                        end else begin
                            // walk down from the tail, moving larger keys up
                            n_idx   = r_cnt;
                            rd_sel  = cnt_m1;
                            n_state = S_CMP;
                        end
                    end else if (i_cmd.operation == sle_pkg::OP_DELETE ||
                                 i_cmd.operation == sle_pkg::OP_SEARCH) begin
                        if (r_cnt == ZERO) begin
                            n_status = sle_pkg::ST_NOT_FOUND;
                            n_valid  = 1'b1;
                        end else begin
                            n_idx   = ZERO;
                            rd_sel  = ZERO;
                            n_state = S_CMP;
                        end
                    end else if (i_cmd.operation == sle_pkg::OP_CLEAR) begin
                        n_cnt   = ZERO;
                        n_valid = 1'b1;
                    end else if (i_cmd.operation == sle_pkg::OP_REWIND) begin
                        n_cur   = ZERO;
                        n_valid = 1'b1;
                    end else if (i_cmd.operation == sle_pkg::OP_NEXT) begin
                        if (r_cur < r_cnt) begin
                            rd_sel  = r_cur;
                            n_state = S_CMP;
                        end else begin
                            n_status = sle_pkg::ST_PAST_END;
                            n_valid  = 1'b1;
                        end
                    end else begin
                        n_valid = 1'b1;
                    end
                end
            end

            S_CMP: begin
                priority if (r_op == sle_pkg::OP_INSERT) begin
                    mem_we = 1'b1;
                    if (cmp.gt) begin
                        mem_wdata = rdata;
                        n_idx     = idx_m1;
                        if (r_idx == ONE) begin
                            n_state = S_PUT;
                        end else begin
                            rd_sel = idx_m2;
                        end
                    end else begin
                        n_cnt   = r_cnt + ONE;
                        n_valid = 1'b1;
                        n_state = S_IDLE;
                    end
                end else if (r_op == sle_pkg::OP_DELETE) begin
                    // once matched, close the gap one entry per cycle
                    if (r_hit) begin
                        mem_we    = 1'b1;
                        mem_waddr = idx_m1[AW-1:0];
                        mem_wdata = rdata;
                    end
                    n_hit = hit_now;
                    if (r_idx == cnt_m1) begin
                        n_valid = 1'b1;
                        n_state = S_IDLE;
                        if (hit_now) begin
                            n_cnt   = cnt_m1;
                            n_found = 1'b1;
                        end else begin
                            n_status = sle_pkg::ST_NOT_FOUND;
                        end
                    end else begin
                        n_idx  = idx_p1;
                        rd_sel = idx_p1;
                    end
                end else if (r_op == sle_pkg::OP_SEARCH) begin
                    if (cmp.eq) begin
                        n_found = 1'b1;
                        n_valid = 1'b1;
                        n_state = S_IDLE;
                    end else if (r_idx == cnt_m1) begin
                        n_status = sle_pkg::ST_NOT_FOUND;
                        n_valid  = 1'b1;
                        n_state  = S_IDLE;
                    end else begin
                        n_idx  = idx_p1;
                        rd_sel = idx_p1;
                    end
                end else begin
                    n_item  = rd_ext[15:0];
                    n_cur   = r_cur + ONE;
                    n_valid = 1'b1;
                    n_state = S_IDLE;
                end
            end

            S_PUT: begin
                mem_we  = 1'b1;
                n_cnt   = r_cnt + ONE;
                n_valid = 1'b1;
                n_state = S_IDLE;
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
            r_cur   <= '0;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_cur   <= n_cur;
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op     <= n_op;
        r_key    <= n_key;
        r_idx    <= n_idx;
        r_hit    <= n_hit;
        r_item   <= n_item;
        r_found  <= n_found;
        r_status <= n_status;
    end

    assign o_busy  = (r_state != S_IDLE);
    assign o_valid = r_valid;

    always_comb begin
        o_result.item_out   = r_item;
        o_result.found      = r_found;
        o_result.count      = cnt_ext[4:0];
        o_result.is_full    = (r_cnt == CAP_CNT);
        o_result.list_empty = (r_cnt == ZERO);
        o_result.status     = r_status;
    end

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CAP_CNT)
        else $error("stored count above capacity");

    a_accept_progress: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !o_busy) |=> (o_busy || o_valid))
        else $error("accepted word neither in progress nor answered");

    a_full_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_result.status == sle_pkg::ST_FULL) |-> o_result.is_full)
        else $error("insert rejected while list not full");

    a_found_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_result.found) |-> (o_result.status == sle_pkg::ST_OK))
        else $error("match reported with error status");

endmodule

`default_nettype wire
